// File: src/bums_pkg.sv
`timescale 1ns / 1ps

package bums_pkg;

  localparam int VALUE_W = 32;
  localparam int MAX_ELEMS_DEF = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    RD_I    = 2'd0,
    RD_J    = 2'd1,
    RD_NEXT = 2'd2,
    RD_K    = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    sort_init;
    logic    run_init;
    rd_sel_t rd_sel;
    logic    cap_l;
    logic    cap_r;
    logic    merge_step;
    logic    refill;
    logic    run_next;
    logic    pass_next;
    logic    out_init;
    logic    out_load;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic sorted;
    logic run_done;
    logic last_run;
    logic out_last;
  } dp_status_t;

endpackage

// File: src/bums_ram.sv
`timescale 1ns / 1ps

module bums_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bums_datapath.sv
`timescale 1ns / 1ps

module bums_datapath #(
  parameter int MAX_ELEMS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bums_pkg::dp_cmd_t             cmd,
  output bums_pkg::dp_status_t          status,
  input  logic [bums_pkg::VALUE_W-1:0]  s_tdata,
  output logic [bums_pkg::VALUE_W-1:0]  m_tdata,
  output logic                          m_tlast,
  output logic                          m_tuser
);

  import bums_pkg::*;

  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = $clog2(MAX_ELEMS + 1);
  localparam int SW = CW + 2;

  logic [CW-1:0] count;
  logic          dropped;
  logic          src;
  logic [CW:0]   width;
  logic [CW-1:0] start;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] k;
  logic [CW-1:0] mid;
  logic [CW-1:0] hi;
  logic          took_l;
  logic signed [DATA_WIDTH-1:0] head_l;
  logic signed [DATA_WIDTH-1:0] head_r;

  logic [SW-1:0] n_ext;
  logic [SW-1:0] end_w;
  logic [SW-1:0] end_2w;
  logic [CW-1:0] mid_calc;
  logic [CW-1:0] hi_calc;
  logic          take_l;
  logic [CW-1:0] ridx;
  logic [AW-1:0] raddr;
  logic signed [DATA_WIDTH-1:0] load_value;
  logic signed [DATA_WIDTH-1:0] merge_value;
  logic signed [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] rdata0;
  logic [DATA_WIDTH-1:0] rdata1;
  logic                  we0;
  logic                  we1;
  logic [AW-1:0]         waddr0;
  logic [DATA_WIDTH-1:0] wdata0;

  assign n_ext    = SW'(count);
  assign end_w    = SW'(start) + SW'(width);
  assign end_2w   = SW'(start) + (SW'(width) << 1);
  assign mid_calc = (end_w < n_ext) ? CW'(end_w) : count;
  assign hi_calc  = (end_2w < n_ext) ? CW'(end_2w) : count;

  assign take_l = (i < mid) && ((j >= hi) || (head_l <= head_r));
  assign merge_value = take_l ? head_l : head_r;
  assign load_value  = DATA_WIDTH'($signed(s_tdata));

  always_comb begin
    case (cmd.rd_sel)
      RD_I:    ridx = i;
      RD_J:    ridx = j;
      RD_NEXT: ridx = take_l ? CW'(i + 1'b1) : CW'(j + 1'b1);
      RD_K:    ridx = k;
      default: ridx = k;
    endcase
  end

  assign raddr = ridx[AW-1:0];

  // bank 0 takes the load; merges ping-pong between banks
  assign we0    = (cmd.load && !status.full) || (cmd.merge_step && src);
  assign we1    = cmd.merge_step && !src;
  assign waddr0 = cmd.load ? count[AW-1:0] : k[AW-1:0];
  assign wdata0 = cmd.load ? load_value : merge_value;

  bums_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(MAX_ELEMS)
  ) u_bank0 (
    .clk  (clk),
    .we   (we0),
    .waddr(waddr0),
    .wdata(wdata0),
    .raddr(raddr),
    .rdata(rdata0)
  );

  bums_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(MAX_ELEMS)
  ) u_bank1 (
    .clk  (clk),
    .we   (we1),
    .waddr(k[AW-1:0]),
    .wdata(merge_value),
    .raddr(raddr),
    .rdata(rdata1)
  );

  assign rdata = src ? rdata1 : rdata0;

  assign status.full     = (count == CW'(MAX_ELEMS));
  assign status.sorted   = (SW'(width) >= n_ext);
  assign status.run_done = (k == hi);
  assign status.last_run = (end_2w >= n_ext);
  assign status.out_last = m_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.finish) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (status.full) begin
        dropped <= 1'b1;
      end else begin
        count <= CW'(count + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      width <= (CW+1)'(1);
      start <= '0;
      src   <= 1'b0;
    end
    if (cmd.run_init) begin
      i   <= start;
      j   <= mid_calc;
      k   <= start;
      mid <= mid_calc;
      hi  <= hi_calc;
    end
    if (cmd.cap_l) begin
      head_l <= rdata;
    end
    if (cmd.cap_r) begin
      head_r <= rdata;
    end
    if (cmd.merge_step) begin
      k      <= CW'(k + 1'b1);
      took_l <= take_l;
      if (take_l) begin
        i <= CW'(i + 1'b1);
      end else begin
        j <= CW'(j + 1'b1);
      end
    end
    if (cmd.refill) begin
      if (took_l) begin
        head_l <= rdata;
      end else begin
        head_r <= rdata;
      end
    end
    if (cmd.run_next) begin
      start <= CW'(end_2w);
    end
    if (cmd.pass_next) begin
      width <= width << 1;
      start <= '0;
      src   <= ~src;
    end
    if (cmd.out_init) begin
      k <= '0;
    end
    if (cmd.out_load) begin
      m_tdata <= VALUE_W'(rdata);
      m_tlast <= (CW'(k + 1'b1) == count);
      m_tuser <= dropped;
      k       <= CW'(k + 1'b1);
    end
  end

endmodule

// File: src/bums_ctrl.sv
`timescale 1ns / 1ps

module bums_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  bums_pkg::dp_status_t status,
  output bums_pkg::dp_cmd_t    cmd,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready
);

  import bums_pkg::*;

  typedef enum logic [11:0] {
    S_LOAD      = 12'b0000_0000_0001,
    S_SORT_INIT = 12'b0000_0000_0010,
    S_CHECK     = 12'b0000_0000_0100,
    S_RUN_INIT  = 12'b0000_0000_1000,
    S_RD_L      = 12'b0000_0001_0000,
    S_RD_R      = 12'b0000_0010_0000,
    S_CAP_R     = 12'b0000_0100_0000,
    S_MERGE     = 12'b0000_1000_0000,
    S_REFILL    = 12'b0001_0000_0000,
    S_OUT_RD    = 12'b0010_0000_0000,
    S_OUT_LD    = 12'b0100_0000_0000,
    S_OUT_WAIT  = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_LOAD);
  assign m_tvalid = (state == S_OUT_WAIT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_K;
    case (state)
      S_LOAD: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_tlast) begin
            state_next = S_SORT_INIT;
          end
        end
      end
      S_SORT_INIT: begin
        cmd.sort_init = 1'b1;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        if (status.sorted) begin
          cmd.out_init = 1'b1;
          state_next   = S_OUT_RD;
        end else begin
          state_next = S_RUN_INIT;
        end
      end
      S_RUN_INIT: begin
        cmd.run_init = 1'b1;
        state_next   = S_RD_L;
      end
      S_RD_L: begin
        cmd.rd_sel = RD_I;
        state_next = S_RD_R;
      end
      S_RD_R: begin
        cmd.cap_l  = 1'b1;
        cmd.rd_sel = RD_J;
        state_next = S_CAP_R;
      end
      S_CAP_R: begin
        cmd.cap_r  = 1'b1;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        if (status.run_done) begin
          if (status.last_run) begin
            cmd.pass_next = 1'b1;
            state_next    = S_CHECK;
          end else begin
            cmd.run_next = 1'b1;
            state_next   = S_RUN_INIT;
          end
        end else begin
          cmd.merge_step = 1'b1;
          cmd.rd_sel     = RD_NEXT;
          state_next     = S_REFILL;
        end
      end
      S_REFILL: begin
        cmd.refill = 1'b1;
        state_next = S_MERGE;
      end
      S_OUT_RD: begin
        state_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.out_load = 1'b1;
        state_next   = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (m_tready) begin
          if (status.out_last) begin
            cmd.finish = 1'b1;
            state_next = S_LOAD;
          end else begin
            state_next = S_OUT_LD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/bottom_up_merge_sorter.sv
`timescale 1ns / 1ps

// Bottom-up merge sorter. Takes signed values one request per cycle until a
// request with tlast arrives, then sorts the set ascending (stable: equal
// values keep arrival order) and sends every kept value out, tlast on the final
// one and tuser set on all of them if requests beyond MAX_ELEMS were dropped.
// The input is not ready while a set is sorted or sent. For a set of n values
// the sort takes ceil(log2 n) passes; each pass does one registered read per
// element in the merge loop, and the two RAM banks share a single read
// address. Read-out holds each result until m_axis_tready takes it.
module bottom_up_merge_sorter #(
  parameter int MAX_ELEMS  = bums_pkg::MAX_ELEMS_DEF,
  parameter int DATA_WIDTH = bums_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bums_pkg::VALUE_W-1:0] s_axis_tdata,  // [31:0] value
  input  logic                         s_axis_tlast,  // is_last
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bums_pkg::VALUE_W-1:0] m_axis_tdata,  // [31:0] sorted_value
  output logic                         m_axis_tlast,  // last_out
  output logic                         m_axis_tuser   // [0] overflow
);

  import bums_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bums_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .status  (status),
    .cmd     (cmd),
    .s_tvalid(s_axis_tvalid),
    .s_tready(s_axis_tready),
    .s_tlast (s_axis_tlast),
    .m_tvalid(m_axis_tvalid),
    .m_tready(m_axis_tready)
  );

  bums_datapath #(
    .MAX_ELEMS (MAX_ELEMS),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .s_tdata(s_axis_tdata),
    .m_tdata(m_axis_tdata),
    .m_tlast(m_axis_tlast),
    .m_tuser(m_axis_tuser)
  );

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is offered");

  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still ready after the last request of a set");

  a_reload_after_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
    else $error("not back to loading after the final result");
`endif

endmodule
